@@ hdl/smf_pkg.sv @@
// Package for the sliding median filter: window size, derived widths,
// the entry type that moves along the sorted cell chain.
// No dependencies.
`timescale 1ns / 1ps

package smf_pkg;

  // Window length in samples
  localparam int WINDOW = 5;

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int MED_W    = SAMPLE_W + 1;
  localparam int HELD_W   = 3;

  // Stream data widths, padded to whole bytes
  localparam int S_TDATA_W = ((SAMPLE_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((MED_W + HELD_W + 7) / 8) * 8;

  // Derived widths: fill count holds 0..WINDOW, age and index hold 0..WINDOW-1
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int AGE_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int IDX_W = AGE_W;

  // Oldest age a held sample can reach before it is evicted
  localparam logic [AGE_W-1:0] AGE_OLDEST = AGE_W'(WINDOW - 1);

  // One slot of the sorted chain: sample, occupied flag, age in beats
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] val;
    logic                       vld;
    logic [AGE_W-1:0]           age;
  } smf_entry_t;

  // Boundary entries: below the first cell sits the most negative value,
  // above the last cell sits an empty slot (counts as +infinity)
  localparam smf_entry_t ENTRY_FLOOR = '{
    val: {1'b1, {(SAMPLE_W-1){1'b0}}}, vld: 1'b1, age: '0};
  localparam smf_entry_t ENTRY_EMPTY = '{val: '0, vld: 1'b0, age: '0};

endpackage : smf_pkg

@@ hdl/sliding_median_filter.sv @@
// Top level of the sliding median filter: sorted cell chain, fill count,
// stream handshakes and the median output stage.
// Depends on smf_pkg, smf_cell, smf_median.
`timescale 1ns / 1ps

// Channel  | Dir | Beat contents (low bit first)
// ---------+-----+-------------------------------------------------
// s_axis   | in  | tdata[15:0] sample
// m_axis   | out | tdata[16:0] median_twice, [19:17] held_count, pad
//
// An accepted sample updates the chain registers and sets a pending flag; its
// result is then loaded into the output register when that is free, so one
// sample per cycle is taken while the output is drained every cycle.
// Throughput is set by the output register: a held result blocks a second
// pending sample. Reset empties the chain and the fill count immediately.

module sliding_median_filter
  import smf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,   // [15:0] sample
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [M_TDATA_W-1:0] m_axis_tdata_o    // [16:0] median_twice, [19:17] held_count
);

  smf_entry_t              chain_w [WINDOW];
  smf_entry_t              left_w  [WINDOW];
  smf_entry_t              right_w [WINDOW];
  logic [WINDOW:0]         seen_w;
  logic [WINDOW-1:0]       vld_w;
  logic signed [SAMPLE_W-1:0] sample;
  logic                    accept, out_free, load;
  logic                    pend_q, pend_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic signed [MED_W-1:0] median_twice;
  logic [HELD_W-1:0]       held_count;

  assign sample = s_axis_tdata_i[SAMPLE_W-1:0];

  // Handshake: a pending result moves out when the output register frees up
  assign out_free        = !m_axis_tvalid_o || m_axis_tready_i;
  assign load            = pend_q && out_free;
  assign s_axis_tready_o = !pend_q || out_free;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    pend_d = pend_q;
    if (accept) begin
      pend_d = 1'b1;
    end else if (load) begin
      pend_d = 1'b0;
    end
  end

  // Fill count saturates at the window length
  always_comb begin
    count_d = count_q;
    if (accept && (count_q != CNT_W'(WINDOW))) begin
      count_d = CNT_W'(count_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= 1'b0;
      count_q <= '0;
    end else begin
      pend_q  <= pend_d;
      count_q <= count_d;
    end
  end

  // Sorted cell chain, lowest value in cell 0
  assign seen_w[0] = 1'b0;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_w[i] = ENTRY_FLOOR;
    end else begin : g_mid
      assign left_w[i] = chain_w[i-1];
    end
    if (i == WINDOW - 1) begin : g_last
      assign right_w[i] = ENTRY_EMPTY;
    end else begin : g_inner
      assign right_w[i] = chain_w[i+1];
    end
    assign vld_w[i] = chain_w[i].vld;

    smf_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ins_i    (accept),
      .sample_i (sample),
      .left_i   (left_w[i]),
      .right_i  (right_w[i]),
      .seen_i   (seen_w[i]),
      .seen_o   (seen_w[i+1]),
      .entry_o  (chain_w[i])
    );
  end

  // Median pick and output register
  smf_median u_median (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (load),
    .take_i         (m_axis_tready_i),
    .chain_i        (chain_w),
    .count_i        (count_q),
    .valid_o        (m_axis_tvalid_o),
    .median_twice_o (median_twice),
    .held_count_o   (held_count)
  );

  assign m_axis_tdata_o = {{(M_TDATA_W-MED_W-HELD_W){1'b0}}, held_count, median_twice};

  // Occupied cells always match the fill count
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == CNT_W'($countones(vld_w)))
    else $error("sliding_median_filter: fill count and chain disagree");

  // An accepted sample always leaves a result pending
  a_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> pend_q)
    else $error("sliding_median_filter: accepted beat lost");

endmodule : sliding_median_filter

@@ hdl/smf_cell.sv @@
// One cell of the sorted sample chain. Holds one entry and, on insert,
// picks its next entry from itself, its two neighbors or the new sample.
// Depends on smf_pkg.
`timescale 1ns / 1ps

module smf_cell
  import smf_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       ins_i,     // insert beat accepted
  input  logic signed [SAMPLE_W-1:0] sample_i,  // new sample
  input  smf_entry_t                 left_i,    // entry of lower neighbor
  input  smf_entry_t                 right_i,   // entry of upper neighbor
  input  logic                       seen_i,    // eviction at a lower cell
  output logic                       seen_o,    // eviction here or below
  output smf_entry_t                 entry_o
);

  smf_entry_t entry_q, entry_d;
  smf_entry_t rem_own, rem_left;
  logic       evict;
  logic       own_above, left_above;

  // Slot is freed when it holds the oldest sample of a full window
  assign evict  = entry_q.vld && (entry_q.age == AGE_OLDEST);
  assign seen_o = seen_i || evict;

  // Chain after removal of the evicted entry: cells at or above it shift down
  assign rem_own  = seen_o ? right_i : entry_q;
  assign rem_left = seen_i ? entry_q : left_i;

  // Empty slots sort above every sample
  assign own_above  = !rem_own.vld  || (rem_own.val  > sample_i);
  assign left_above = !rem_left.vld || (rem_left.val > sample_i);

  // Insert: keep lower values, take the sample at its slot, shift the rest up
  always_comb begin
    if (!own_above) begin
      entry_d     = rem_own;
      entry_d.age = AGE_W'(rem_own.age + 1'b1);
    end else if (!left_above) begin
      entry_d.val = sample_i;
      entry_d.vld = 1'b1;
      entry_d.age = '0;
    end else begin
      entry_d     = rem_left;
      entry_d.age = AGE_W'(rem_left.age + 1'b1);
    end
  end

  // Entry register; reset leaves the slot empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= ENTRY_EMPTY;
    end else if (ins_i) begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

  // Chain stays sorted and occupied slots stay packed at the low end
  a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (entry_q.vld && right_i.vld) |-> (entry_q.val <= right_i.val))
    else $error("smf_cell: chain out of order");

  a_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    right_i.vld |-> entry_q.vld)
    else $error("smf_cell: gap in occupied slots");

endmodule : smf_cell

@@ hdl/smf_median.sv @@
// Median pick and output register: selects the middle entries of the sorted
// chain, adds them into the doubled median and holds the result beat.
// Depends on smf_pkg.
`timescale 1ns / 1ps

module smf_median
  import smf_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    load_i,               // capture a new result
  input  logic                    take_i,               // downstream ready
  input  smf_entry_t              chain_i [WINDOW],     // sorted chain
  input  logic [CNT_W-1:0]        count_i,              // samples held, >= 1
  output logic                    valid_o,
  output logic signed [MED_W-1:0] median_twice_o,
  output logic [HELD_W-1:0]       held_count_o
);

  logic [CNT_W-1:0]        cnt_dec;
  logic [IDX_W-1:0]        idx_lo, idx_hi;
  logic signed [MED_W-1:0] sum;
  logic                    valid_q;
  logic signed [MED_W-1:0] median_q;
  logic [HELD_W-1:0]       held_q;

  // Middle indices: equal for an odd count, adjacent for an even count
  assign cnt_dec = count_i - 1'b1;
  assign idx_lo  = IDX_W'(cnt_dec >> 1);
  assign idx_hi  = IDX_W'(count_i >> 1);

  assign sum = MED_W'(chain_i[idx_lo].val) + MED_W'(chain_i[idx_hi].val);

  // Result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      median_q <= sum;
      held_q   <= HELD_W'(count_i);
    end
  end

  assign valid_o        = valid_q;
  assign median_twice_o = median_q;
  assign held_count_o   = held_q;

endmodule : smf_median

@@ test/tb.sv @@
// Self-checking bench for sliding_median_filter: streams signed samples and
// compares each median beat with a running-window median computed in the bench.
// Depends on smf_pkg and the sliding_median_filter RTL.
`timescale 1ns / 1ps

module tb;
  import smf_pkg::*;

  // No beat on either side for this many cycles ends the run
  localparam int STALL_LIMIT = 2000;
  // Cycles to wait after the last expected median has drained
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic signed [MED_W-1:0] med_twice;
    logic [HELD_W-1:0]       held;
  } median_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [S_TDATA_W-1:0] s_axis_tdata_i;   // [15:0] sample
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  logic [M_TDATA_W-1:0] m_axis_tdata_o;   // [16:0] median_twice, [19:17] held_count

  sliding_median_filter u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // Bench copy of the window: ring store, write position, fill level
  logic signed [SAMPLE_W-1:0] ring_q [WINDOW];
  int                         ring_wr;
  int                         ring_fill;

  median_t pending_medians [$];

  int err_cnt;
  int samples_sent;
  int medians_checked;
  int idle_cycles;
  int src_idle_pct;
  int snk_stall_pct;
  logic signed [SAMPLE_W-1:0] cluster_base;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Sink side: tready redrawn every falling edge
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready_i <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  task automatic report_mismatch(input string what, input int got, input int exp);
    $display("tb: %0t median beat %0d: %s got %0d expected %0d",
             $time, medians_checked, what, got, exp);
    err_cnt++;
  endtask

  // Add one sample to the window and queue the median it should produce
  task automatic median_update(input logic signed [SAMPLE_W-1:0] smp);
    int      vals [WINDOW];
    int      i;
    int      j;
    int      key;
    int      twice;
    median_t m;
    ring_q[ring_wr] = smp;
    ring_wr = (ring_wr + 1) % WINDOW;
    if (ring_fill < WINDOW) ring_fill++;
    // held slots are 0..fill-1 since writing starts at slot 0
    for (i = 0; i < ring_fill; i++) vals[i] = ring_q[i];
    // insertion sort of the held samples
    for (i = 1; i < ring_fill; i++) begin
      key = vals[i];
      j = i;
      while (j > 0 && vals[j-1] > key) begin
        vals[j] = vals[j-1];
        j--;
      end
      vals[j] = key;
    end
    if (ring_fill % 2 == 0) begin
      twice = vals[ring_fill/2 - 1] + vals[ring_fill/2];
    end else begin
      twice = 2 * vals[ring_fill/2];
    end
    m.med_twice = MED_W'(twice);
    m.held      = HELD_W'(ring_fill);
    pending_medians.push_back(m);
  endtask

  // Drive one sample beat, with random source gaps, and wait for acceptance
  task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= S_TDATA_W'(smp);
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    median_update(smp);
    samples_sent++;
  endtask

  // Random sample: full range, extremes, or a tight cluster that makes ties
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    logic [SAMPLE_W-1:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = SAMPLE_W'($urandom_range(16'hFFFF));
      4, 5: begin
        case ($urandom_range(3))
          0:       v = 16'h8000;
          1:       v = 16'h7FFF;
          2:       v = 16'h0000;
          default: v = 16'hFFFF;
        endcase
      end
      default: v = cluster_base + SAMPLE_W'($urandom_range(6)) - SAMPLE_W'(3);
    endcase
    return v;
  endfunction

  // Result checker: compare each median beat with the oldest expectation
  always @(posedge clk_i) begin
    median_t exp_m;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_medians.size() == 0) begin
        $display("tb: %0t median beat with nothing expected, data %h",
                 $time, m_axis_tdata_o);
        err_cnt++;
      end else begin
        exp_m = pending_medians.pop_front();
        if ($signed(m_axis_tdata_o[MED_W-1:0]) !== exp_m.med_twice)
          report_mismatch("median_twice", $signed(m_axis_tdata_o[MED_W-1:0]),
                          exp_m.med_twice);
        if (m_axis_tdata_o[MED_W +: HELD_W] !== exp_m.held)
          report_mismatch("held_count", m_axis_tdata_o[MED_W +: HELD_W], exp_m.held);
      end
      medians_checked++;
    end
  end

  // Watchdog: too long without a beat on either side
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((s_axis_tvalid_i && s_axis_tready_o) ||
                 (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("tb: %0t no beat for %0d cycles, %0d medians still expected",
                 $time, STALL_LIMIT, pending_medians.size());
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  // Window filling from reset: counts 1..5, odd and even, then the first evictions
  task automatic test_window_fill();
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'h7FFF);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
  endtask

  // Full window: all-min, all-max, alternating bit patterns, small values
  task automatic test_full_window();
    repeat (5) send_sample(16'h8000);
    repeat (5) send_sample(16'h7FFF);
    send_sample(16'h5555);
    send_sample(16'hAAAA);
    send_sample(16'h0001);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
  endtask

  // Random stream under one idling mix
  task automatic test_random_stream(input int src_pct, input int snk_pct, input int n);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(15) == 0) cluster_base = SAMPLE_W'($urandom_range(16'hFFFF));
      send_sample(pick_sample());
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    err_cnt         = 0;
    samples_sent    = 0;
    medians_checked = 0;
    src_idle_pct    = 0;
    snk_stall_pct   = 0;
    cluster_base    = '0;
    ring_wr         = 0;
    ring_fill       = 0;
    for (int i = 0; i < WINDOW; i++) ring_q[i] = '0;

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    test_window_fill();
    test_full_window();
    test_random_stream(0, 0, 125);
    test_random_stream(72, 0, 125);
    test_random_stream(0, 72, 125);
    test_random_stream(18, 18, 125);

    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_medians.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("tb: %0d samples sent, %0d medians checked, %0d mismatches",
             samples_sent, medians_checked, err_cnt);
    $display("tb: covered window fill, full-range extremes, ties and four idle mixes");
    if (err_cnt == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/smf_pkg.sv
hdl/smf_cell.sv
hdl/smf_median.sv
hdl/sliding_median_filter.sv
test/tb.sv
